// ----- rtl/core/imf_pkg.sv -----
// Package for the ISAP maximum-flow block: beat types, fixed field widths
// and configuration register indexes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package imf_pkg;

  localparam int NODE_ID_W = 6;
  localparam int CAP_WIDTH = 16;
  localparam int FLOW_W    = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int NODE_COUNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINK_NODE   = 2'd2;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
  localparam logic [NODE_ID_W-1:0]    SOURCE_RESET     = 6'd0;
  localparam logic [NODE_ID_W-1:0]    SINK_RESET       = 6'd1;

  typedef struct packed {
    logic [NODE_ID_W-1:0] edge_tail;
    logic [NODE_ID_W-1:0] edge_head;
    logic [CAP_WIDTH-1:0] edge_capacity;
    logic                 last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [FLOW_W-1:0] total_flow;
    logic              edges_dropped;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/imf_ram.sv -----
// Single-port-write, single-port-read synchronous memory with a registered read.
// Used for every table of the flow solver. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module imf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/isap_max_flow_top.sv -----
// Top level of the ISAP maximum-flow block: edge loading, reverse BFS labelling
// and the ISAP search with the gap rule. Depends on imf_pkg and imf_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage.
// Edges arrive on edge_item; a beat is taken when start is high and busy is
// low. Each stored edge is accepted and then its forward and reverse arcs are
// linked into the adjacency tables. An edge that does not fit is dropped and
// flagged.
// After a beat with last_edge set the block stays busy while it solves. The
// labelling pass first initialises the node tables and then visits nodes and
// arcs; each ISAP advance, retreat and augmenting step then scans arcs, and
// every arc and every node label is fetched from a memory with a registered
// read.
// Done is high for exactly one cycle, with the answer on result; the
// receiver cannot hold it off. The graph is cleared at that moment.
// Configuration writes through cfg_write, cfg_index and cfg_data take effect at
// once and must only be made while busy is low and no result is pending.
// Reset empties the graph, clears the drop flag and restores node_count 64,
// source_node 0 and sink_node 1; no memory clearing pass is needed.
module isap_max_flow_top #(
  parameter int NODE_LIMIT = 64,
  parameter int MAX_ARCS  = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire imf_pkg::edge_item_t                edge_item,
  output logic                                    done,
  output imf_pkg::result_t                        result,
  input  wire logic                               cfg_write,
  input  wire logic [imf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [imf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NODE_W = $clog2(NODE_LIMIT);
  localparam int LBL_W  = $clog2(NODE_LIMIT + 1);
  localparam int PAIRS  = MAX_ARCS / 2;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PCNT_W = $clog2(PAIRS + 1);
  localparam int ARC_W  = PAIR_W + 2;
  localparam int CAP_W  = imf_pkg::CAP_WIDTH;
  localparam int FLOW_W = imf_pkg::FLOW_W;
  localparam int ROW_W  = 2 * NODE_W + 2 * CAP_W + 2 * ARC_W;
  localparam logic [ARC_W-1:0] NO_ARC = ARC_W'(MAX_ARCS);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_L_HF  = 6'd1;
  localparam logic [5:0] S_L_HT  = 6'd2;
  localparam logic [5:0] S_CHECK = 6'd3;
  localparam logic [5:0] S_INIT  = 6'd4;
  localparam logic [5:0] S_B_POP = 6'd5;
  localparam logic [5:0] S_B_X   = 6'd6;
  localparam logic [5:0] S_B_XL  = 6'd7;
  localparam logic [5:0] S_B_ARC = 6'd8;
  localparam logic [5:0] S_B_ROW = 6'd9;
  localparam logic [5:0] S_B_VIS = 6'd10;
  localparam logic [5:0] S_B_CNT = 6'd11;
  localparam logic [5:0] S_B_END = 6'd12;
  localparam logic [5:0] S_B_SRC = 6'd13;
  localparam logic [5:0] S_N_TOP = 6'd14;
  localparam logic [5:0] S_N_LD  = 6'd15;
  localparam logic [5:0] S_F_ARC = 6'd16;
  localparam logic [5:0] S_F_ROW = 6'd17;
  localparam logic [5:0] S_F_LBL = 6'd18;
  localparam logic [5:0] S_R_ARC = 6'd19;
  localparam logic [5:0] S_R_ROW = 6'd20;
  localparam logic [5:0] S_R_LBL = 6'd21;
  localparam logic [5:0] S_R_DEC = 6'd22;
  localparam logic [5:0] S_R_INC = 6'd23;
  localparam logic [5:0] S_R_PAR = 6'd24;
  localparam logic [5:0] S_R_PRW = 6'd25;
  localparam logic [5:0] S_A_PAR = 6'd26;
  localparam logic [5:0] S_A_PA  = 6'd27;
  localparam logic [5:0] S_A_ROW = 6'd28;
  localparam logic [5:0] S_U_PAR = 6'd29;
  localparam logic [5:0] S_U_PA  = 6'd30;
  localparam logic [5:0] S_U_ROW = 6'd31;
  localparam logic [5:0] S_EMIT  = 6'd32;

  logic [5:0] state;

  logic [imf_pkg::NODE_COUNT_W-1:0] node_count;
  logic [imf_pkg::NODE_ID_W-1:0]    source_node;
  logic [imf_pkg::NODE_ID_W-1:0]    sink_node;

  logic [PCNT_W-1:0]     pcnt;
  logic                  overflow;
  logic [NODE_LIMIT-1:0] head_ok;
  logic [NODE_LIMIT-1:0] cur_ok;

  logic [NODE_W-1:0] e_tail;
  logic [NODE_W-1:0] e_head;
  logic [CAP_W-1:0]  e_cap;
  logic              e_last;
  logic [ARC_W-1:0]  hf;

  logic [LBL_W-1:0]  n;
  logic [NODE_W-1:0] s;
  logic [NODE_W-1:0] t;
  logic [LBL_W-1:0]  cnt;
  logic [LBL_W-1:0]  qh;
  logic [LBL_W-1:0]  qt;
  logic [NODE_W-1:0] xn;
  logic [LBL_W-1:0]  dx;
  logic [ARC_W-1:0]  a;
  logic [ARC_W-1:0]  a_next;
  logic [NODE_W-1:0] y;
  logic [NODE_W-1:0] u;
  logic [NODE_W-1:0] v;
  logic [LBL_W-1:0]  du;
  logic [ARC_W-1:0]  hu;
  logic [LBL_W-1:0]  ds;
  logic [LBL_W-1:0]  m;
  logic [LBL_W-1:0]  wsave;
  logic [CAP_W:0]    df;
  logic [FLOW_W-1:0] flow;

  logic [LBL_W-1:0]  n_eff;
  logic              fits;
  logic [ARC_W-1:0]  arc_base;

  // Memory ports.
  logic              pair_we;
  logic [PAIR_W-1:0] pair_waddr;
  logic [ROW_W-1:0]  pair_wdata;
  logic [PAIR_W-1:0] pair_raddr;
  logic [ROW_W-1:0]  pair_rd;
  logic              head_we;
  logic [NODE_W-1:0] head_waddr;
  logic [ARC_W-1:0]  head_wdata;
  logic [NODE_W-1:0] head_raddr;
  logic [ARC_W-1:0]  head_rd;
  logic              lbl_we;
  logic [NODE_W-1:0] lbl_waddr;
  logic [LBL_W-1:0]  lbl_wdata;
  logic [NODE_W-1:0] lbl_raddr;
  logic [LBL_W-1:0]  lbl_rd;
  logic              cur_we;
  logic [NODE_W-1:0] cur_waddr;
  logic [ARC_W-1:0]  cur_wdata;
  logic [NODE_W-1:0] cur_raddr;
  logic [ARC_W-1:0]  cur_rd;
  logic              par_we;
  logic [NODE_W-1:0] par_waddr;
  logic [ARC_W-1:0]  par_wdata;
  logic [NODE_W-1:0] par_raddr;
  logic [ARC_W-1:0]  par_rd;
  logic              pop_we;
  logic [LBL_W-1:0]  pop_waddr;
  logic [LBL_W-1:0]  pop_wdata;
  logic [LBL_W-1:0]  pop_raddr;
  logic [LBL_W-1:0]  pop_rd;
  logic              q_we;
  logic [NODE_W-1:0] q_waddr;
  logic [NODE_W-1:0] q_wdata;
  logic [NODE_W-1:0] q_raddr;
  logic [NODE_W-1:0] q_rd;

  // Fields of the arc pair just read, seen from arc a.
  logic [NODE_W-1:0] r_tail;
  logic [NODE_W-1:0] r_head;
  logic [CAP_W-1:0]  r_cap;
  logic [CAP_W-1:0]  r_flow;
  logic [ARC_W-1:0]  r_nf;
  logic [ARC_W-1:0]  r_nr;
  logic [NODE_W-1:0] arc_to;
  logic [NODE_W-1:0] arc_from;
  logic [CAP_W-1:0]  resid_a;
  logic [CAP_W-1:0]  resid_rev;
  logic [ARC_W-1:0]  nxt;
  logic              live;
  logic [LBL_W-1:0]  m_inc;
  logic [LBL_W-1:0]  dec_val;

  assign {r_tail, r_head, r_cap, r_flow, r_nf, r_nr} = pair_rd;
  assign arc_to    = a[0] ? r_tail : r_head;
  assign arc_from  = a[0] ? r_head : r_tail;
  assign resid_a   = a[0] ? r_flow : r_cap - r_flow;
  assign resid_rev = a[0] ? r_cap - r_flow : r_flow;
  assign nxt       = a[0] ? r_nr : r_nf;
  assign live      = (32'(r_tail) < 32'(n)) && (32'(r_head) < 32'(n));
  assign m_inc     = m + LBL_W'(1);
  assign dec_val   = pop_rd - LBL_W'(1);
  assign arc_base  = {1'b0, PAIR_W'(pcnt), 1'b0};

  assign fits = (32'(edge_item.edge_tail) < NODE_LIMIT) &&
                (32'(edge_item.edge_head) < NODE_LIMIT) && (32'(pcnt) < PAIRS);

  always_comb begin
    if (32'(node_count) < 2) begin
      n_eff = LBL_W'(2);
    end else if (32'(node_count) > NODE_LIMIT) begin
      n_eff = LBL_W'(NODE_LIMIT);
    end else begin
      n_eff = LBL_W'(node_count);
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= imf_pkg::NODE_COUNT_RESET;
      source_node <= imf_pkg::SOURCE_RESET;
      sink_node   <= imf_pkg::SINK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        imf_pkg::REG_NODE_COUNT:  node_count  <= cfg_data;
        imf_pkg::REG_SOURCE_NODE: source_node <= cfg_data[imf_pkg::NODE_ID_W-1:0];
        imf_pkg::REG_SINK_NODE:   sink_node   <= cfg_data[imf_pkg::NODE_ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pair_we = 1'b0;  pair_waddr = '0; pair_wdata = '0; pair_raddr = a[PAIR_W:1];
    head_we = 1'b0;  head_waddr = '0; head_wdata = '0; head_raddr = u;
    lbl_we  = 1'b0;  lbl_waddr  = '0; lbl_wdata  = '0; lbl_raddr  = u;
    cur_we  = 1'b0;  cur_waddr  = u;  cur_wdata  = a;  cur_raddr  = u;
    par_we  = 1'b0;  par_waddr  = y;  par_wdata  = a;  par_raddr  = v;
    pop_we  = 1'b0;  pop_waddr  = '0; pop_wdata  = '0; pop_raddr  = du;
    q_we    = 1'b0;  q_waddr    = '0; q_wdata    = t;  q_raddr    = NODE_W'(qh);
    unique case (state)
      S_IDLE: begin
        head_raddr = NODE_W'(edge_item.edge_tail);
      end
      S_L_HF: begin
        head_we    = 1'b1;
        head_waddr = e_tail;
        head_wdata = arc_base;
        head_raddr = e_head;
      end
      S_L_HT: begin
        head_we    = 1'b1;
        head_waddr = e_head;
        head_wdata = arc_base | ARC_W'(1);
        pair_we    = 1'b1;
        pair_waddr = PAIR_W'(pcnt);
        pair_wdata = {e_tail, e_head, e_cap, CAP_W'(0), hf,
                      (e_head == e_tail) ? arc_base :
                      (head_ok[e_head] ? head_rd : NO_ARC)};
      end
      S_CHECK: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = NODE_W'(sink_node);
      end
      S_INIT: begin
        lbl_we    = (32'(cnt) < NODE_LIMIT);
        lbl_waddr = NODE_W'(cnt);
        lbl_wdata = (32'(cnt) == 32'(t)) ? '0 : n;
        pop_we    = 1'b1;
        pop_waddr = cnt;
        pop_wdata = (cnt == '0) ? LBL_W'(1) : '0;
      end
      S_B_X: begin
        lbl_raddr  = q_rd;
        head_raddr = q_rd;
      end
      S_B_ROW: begin
        lbl_raddr = arc_to;
      end
      S_B_VIS: begin
        lbl_we    = (lbl_rd == n);
        lbl_waddr = y;
        lbl_wdata = dx + LBL_W'(1);
        q_we      = (lbl_rd == n);
        q_waddr   = NODE_W'(qt);
        q_wdata   = y;
        pop_raddr = dx + LBL_W'(1);
      end
      S_B_CNT: begin
        pop_we    = 1'b1;
        pop_waddr = dx + LBL_W'(1);
        pop_wdata = pop_rd + LBL_W'(1);
      end
      S_B_END: begin
        lbl_raddr = s;
      end
      S_B_SRC: begin
        pop_we    = (lbl_rd != n);
        pop_waddr = n;
        pop_wdata = n - qt;
      end
      S_F_ROW, S_R_ROW: begin
        lbl_raddr = arc_to;
      end
      S_F_LBL: begin
        par_we = ((LBL_W + 1)'(lbl_rd) + (LBL_W + 1)'(1) == (LBL_W + 1)'(du));
        cur_we = par_we;
      end
      S_R_DEC: begin
        pop_we    = 1'b1;
        pop_waddr = du;
        pop_wdata = dec_val;
        lbl_we    = (dec_val != '0);
        lbl_waddr = u;
        lbl_wdata = m_inc;
        pop_raddr = m_inc;
      end
      S_R_INC: begin
        pop_we    = 1'b1;
        pop_waddr = m_inc;
        pop_wdata = ((m_inc == du) ? wsave : pop_rd) + LBL_W'(1);
        par_raddr = u;
      end
      S_R_PAR, S_A_PA, S_U_PA: begin
        pair_raddr = par_rd[PAIR_W:1];
      end
      S_U_ROW: begin
        pair_we    = 1'b1;
        pair_waddr = a[PAIR_W:1];
        pair_wdata = {r_tail, r_head, r_cap,
                      a[0] ? r_flow - CAP_W'(df) : r_flow + CAP_W'(df), r_nf, r_nr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pcnt     <= '0;
      overflow <= 1'b0;
      head_ok  <= '0;
      cur_ok   <= '0;
      done     <= 1'b0;
    end else begin
      done <= (state == S_EMIT);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            e_tail <= NODE_W'(edge_item.edge_tail);
            e_head <= NODE_W'(edge_item.edge_head);
            e_cap  <= edge_item.edge_capacity;
            e_last <= edge_item.last_edge;
            if (fits) begin
              state <= S_L_HF;
            end else begin
              overflow <= 1'b1;
              if (edge_item.last_edge) begin
                state <= S_CHECK;
              end
            end
          end
        end
        S_L_HF: begin
          hf              <= head_ok[e_tail] ? head_rd : NO_ARC;
          head_ok[e_tail] <= 1'b1;
          state           <= S_L_HT;
        end
        S_L_HT: begin
          head_ok[e_head] <= 1'b1;
          pcnt            <= pcnt + PCNT_W'(1);
          state           <= e_last ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          n      <= n_eff;
          s      <= NODE_W'(source_node);
          t      <= NODE_W'(sink_node);
          cnt    <= '0;
          qh     <= '0;
          qt     <= LBL_W'(1);
          flow   <= '0;
          cur_ok <= '0;
          if ((32'(source_node) >= 32'(n_eff)) || (32'(sink_node) >= 32'(n_eff)) ||
              (source_node == sink_node)) begin
            state <= S_EMIT;
          end else begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          cnt <= cnt + LBL_W'(1);
          if (32'(cnt) == NODE_LIMIT) begin
            state <= S_B_POP;
          end
        end
        S_B_POP: begin
          if (qh == qt) begin
            state <= S_B_END;
          end else begin
            qh    <= qh + LBL_W'(1);
            state <= S_B_X;
          end
        end
        S_B_X: begin
          xn    <= q_rd;
          state <= S_B_XL;
        end
        S_B_XL: begin
          dx    <= lbl_rd;
          a     <= head_ok[xn] ? head_rd : NO_ARC;
          state <= S_B_ARC;
        end
        S_B_ARC: begin
          state <= (a == NO_ARC) ? S_B_POP : S_B_ROW;
        end
        S_B_ROW: begin
          a_next <= nxt;
          y      <= arc_to;
          if (live && (resid_rev != '0) && (32'(qt) < NODE_LIMIT)) begin
            state <= S_B_VIS;
          end else begin
            a     <= nxt;
            state <= S_B_ARC;
          end
        end
        S_B_VIS: begin
          if (lbl_rd == n) begin
            qt    <= qt + LBL_W'(1);
            state <= S_B_CNT;
          end else begin
            a     <= a_next;
            state <= S_B_ARC;
          end
        end
        S_B_CNT: begin
          a     <= a_next;
          state <= S_B_ARC;
        end
        S_B_END: begin
          state <= S_B_SRC;
        end
        S_B_SRC: begin
          ds <= lbl_rd;
          u  <= s;
          state <= (lbl_rd == n) ? S_EMIT : S_N_TOP;
        end
        S_N_TOP: begin
          if (ds >= n) begin
            state <= S_EMIT;
          end else if (u == t) begin
            v     <= t;
            df    <= (CAP_W + 1)'(1) << CAP_W;
            state <= S_A_PAR;
          end else begin
            state <= S_N_LD;
          end
        end
        S_N_LD: begin
          du    <= lbl_rd;
          hu    <= head_ok[u] ? head_rd : NO_ARC;
          a     <= cur_ok[u] ? cur_rd : (head_ok[u] ? head_rd : NO_ARC);
          state <= S_F_ARC;
        end
        S_F_ARC: begin
          if (a == NO_ARC) begin
            m     <= n - LBL_W'(1);
            a     <= hu;
            state <= S_R_ARC;
          end else begin
            state <= S_F_ROW;
          end
        end
        S_F_ROW: begin
          a_next <= nxt;
          y      <= arc_to;
          if (live && (resid_a != '0)) begin
            state <= S_F_LBL;
          end else begin
            a     <= nxt;
            state <= S_F_ARC;
          end
        end
        S_F_LBL: begin
          if ((LBL_W + 1)'(lbl_rd) + (LBL_W + 1)'(1) == (LBL_W + 1)'(du)) begin
            cur_ok[u] <= 1'b1;
            u         <= y;
            state     <= S_N_TOP;
          end else begin
            a     <= a_next;
            state <= S_F_ARC;
          end
        end
        S_R_ARC: begin
          state <= (a == NO_ARC) ? S_R_DEC : S_R_ROW;
        end
        S_R_ROW: begin
          a_next <= nxt;
          if (live && (resid_a != '0)) begin
            state <= S_R_LBL;
          end else begin
            a     <= nxt;
            state <= S_R_ARC;
          end
        end
        S_R_LBL: begin
          if (lbl_rd < m) begin
            m <= lbl_rd;
          end
          a     <= a_next;
          state <= S_R_ARC;
        end
        S_R_DEC: begin
          wsave <= dec_val;
          if (dec_val == '0) begin
            state <= S_EMIT;
          end else begin
            cur_ok[u] <= 1'b0;
            if (u == s) begin
              ds <= m_inc;
            end
            state <= S_R_INC;
          end
        end
        S_R_INC: begin
          state <= (u == s) ? S_N_TOP : S_R_PAR;
        end
        S_R_PAR: begin
          a     <= par_rd;
          state <= S_R_PRW;
        end
        S_R_PRW: begin
          u     <= arc_from;
          state <= S_N_TOP;
        end
        S_A_PAR: begin
          if (v == s) begin
            v     <= t;
            state <= S_U_PAR;
          end else begin
            state <= S_A_PA;
          end
        end
        S_A_PA: begin
          a     <= par_rd;
          state <= S_A_ROW;
        end
        S_A_ROW: begin
          if ({1'b0, resid_a} < df) begin
            df <= {1'b0, resid_a};
          end
          v     <= arc_from;
          state <= S_A_PAR;
        end
        S_U_PAR: begin
          if (v == s) begin
            flow  <= flow + FLOW_W'(df);
            u     <= s;
            state <= S_N_TOP;
          end else begin
            state <= S_U_PA;
          end
        end
        S_U_PA: begin
          a     <= par_rd;
          state <= S_U_ROW;
        end
        S_U_ROW: begin
          v     <= arc_from;
          state <= S_U_PAR;
        end
        S_EMIT: begin
          result.total_flow    <= flow;
          result.edges_dropped <= overflow;
          head_ok              <= '0;
          pcnt                 <= '0;
          overflow             <= 1'b0;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  imf_ram #(.WIDTH(ROW_W), .DEPTH(PAIRS)) u_pair_ram (
    .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
    .raddr(pair_raddr), .rdata(pair_rd)
  );

  imf_ram #(.WIDTH(ARC_W), .DEPTH(NODE_LIMIT)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );

  imf_ram #(.WIDTH(LBL_W), .DEPTH(NODE_LIMIT)) u_label_ram (
    .clk(clk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
    .raddr(lbl_raddr), .rdata(lbl_rd)
  );

  imf_ram #(.WIDTH(ARC_W), .DEPTH(NODE_LIMIT)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rd)
  );

  imf_ram #(.WIDTH(ARC_W), .DEPTH(NODE_LIMIT)) u_parent_ram (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rd)
  );

  imf_ram #(.WIDTH(LBL_W), .DEPTH(NODE_LIMIT + 1)) u_pop_ram (
    .clk(clk), .we(pop_we), .waddr(pop_waddr), .wdata(pop_wdata),
    .raddr(pop_raddr), .rdata(pop_rd)
  );

  imf_ram #(.WIDTH(NODE_W), .DEPTH(NODE_LIMIT)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rd)
  );

`ifndef ASSERT_OFF
  a_last_starts_solve: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && edge_item.last_edge) |=> busy)
    else $error("last edge beat did not start a solve");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one beat");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pcnt) <= PAIRS)
    else $error("arc pair count beyond table size");
`endif

endmodule

`default_nettype wire
